// ===== rtl/external_memory_bus_sequencer_assert.svh =====
// Assertion macros for the external memory bus sequencer checker
`ifndef EXTERNAL_MEMORY_BUS_SEQUENCER_ASSERT_SVH
`define EXTERNAL_MEMORY_BUS_SEQUENCER_ASSERT_SVH

// same-cycle implication, sampled on clk, idle during reset
`define EMBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bus sequencer check failed");

// next-cycle implication, sampled on clk, idle during reset
`define EMBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bus sequencer check failed");

`endif

// ===== rtl/embs_pkg.sv =====
// Package: types and constants of the external memory bus sequencer
package embs_pkg;

  localparam int DATA_W     = 8;
  localparam int ADDR_W     = 16;
  localparam int TIME_W     = 16;
  localparam int HIGH_SHIFT = 8;
  localparam int KIND_W     = 2;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;

  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

  localparam int MODE_LA = 0;
  localparam int MODE_RW = 1;
  localparam int MODE_EN = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LATCH_ON    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LATCH_OFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SETUP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SETUP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LAEN,
    PH_ADDR,
    PH_LADI,
    PH_DATA,
    PH_READ
  } phase_t;

endpackage

// ===== rtl/external_memory_bus_sequencer.sv =====
// External memory bus sequencer: timed strobe and pin control for a multiplexed bus
//
// Use:
//   in_*   request channel (valid/ready). kind 0 is a tick, 1 a read, 2 a write.
//          A read or write arms an access; each tick while busy advances the elapsed
//          count and runs every phase whose programmed time has been reached, in order.
//   out_*  result channel (valid/ready). One result per request: the pin and strobe
//          levels after that request, read data, read_done, busy and overlap flags.
//   cfg_*  write channel for the six phase times, always ready; write while idle.
// Path: a request is held in the input register, then its result is loaded into the
// result register, where the receiver takes it.
// Throughput: one request per cycle while out_ready is high; the phase chain of a tick
// settles combinationally between the input register and the result register.
// Stall: while out_ready is low the result holds and one more request is taken into
// the input register; in_ready then drops until the result is taken.
// Reset: synchronous, active low; strobes go to rw high, enable high, latch low, pins
// to zero with the data pins as inputs, all phase times to zero, no result pending.
module external_memory_bus_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [embs_pkg::KIND_W-1:0]    in_kind,
  input  logic [embs_pkg::ADDR_W-1:0]    in_address,
  input  logic [embs_pkg::DATA_W-1:0]    in_write_value,
  input  logic [embs_pkg::MODE_W-1:0]    in_mode_flags,
  input  logic [embs_pkg::DATA_W-1:0]    in_bus_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_rw_level,
  output logic                           out_enable_level,
  output logic                           out_latch_level,
  output logic [embs_pkg::ADDR_W-1:0]    out_address_pins,
  output logic [embs_pkg::DATA_W-1:0]    out_data_pins_out,
  output logic                           out_data_pins_drive,
  output logic [embs_pkg::DATA_W-1:0]    out_read_value,
  output logic                           out_read_done,
  output logic                           out_busy_res,
  output logic                           out_overlap_error,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [embs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [embs_pkg::TIME_W-1:0]    cfg_data
);
  import embs_pkg::*;

  logic [TIME_W-1:0] latch_on_r, address_t_r, latch_off_r;
  logic [TIME_W-1:0] read_setup_r, write_setup_r, read_sample_r;

  logic              s1_valid_r;
  logic [KIND_W-1:0] s1_kind_r;
  logic [ADDR_W-1:0] s1_address_r;
  logic [DATA_W-1:0] s1_write_value_r;
  logic [MODE_W-1:0] s1_mode_r;
  logic [DATA_W-1:0] s1_bus_r;

  phase_t            phase_r, phase_nxt, step_ph;
  logic [TIME_W-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic              is_read_r, is_read_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [ADDR_W-1:0] acc_addr_r, acc_addr_nxt;
  logic [DATA_W-1:0] acc_data_r, acc_data_nxt;
  logic              rw_r, rw_nxt;
  logic              enable_r, enable_nxt;
  logic              latch_r, latch_nxt;
  logic [ADDR_W-1:0] addr_pin_r, addr_pin_nxt;
  logic [DATA_W-1:0] data_out_r, data_out_nxt;
  logic              drive_r, drive_nxt;
  logic [DATA_W-1:0] captured_r, captured_nxt;

  logic out_valid_r;
  logic s1_fire, req, tick;
  logic t_laen, t_addr, t_ladi, t_data, t_read;
  logic run_laen, run_addr, run_ladi, run_data, run_read;

  assign cfg_ready = 1'b1;
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || !out_valid_r || out_ready;

  assign req  = s1_fire && (s1_kind_r == KIND_READ || s1_kind_r == KIND_WRITE);
  assign tick = s1_fire && (s1_kind_r == KIND_TICK) && (phase_r != PH_IDLE);

  assign elapsed_inc = (elapsed_r != {TIME_W{1'b1}}) ? elapsed_r + {{(TIME_W-1){1'b0}}, 1'b1}
                                                     : elapsed_r;
  assign mode_nxt = (req && s1_kind_r == KIND_READ) ? s1_mode_r : mode_r;

  assign t_laen = latch_on_r <= elapsed_inc;
  assign t_addr = address_t_r <= elapsed_inc;
  assign t_ladi = latch_off_r <= elapsed_inc;
  assign t_data = (is_read_r ? read_setup_r : write_setup_r) <= elapsed_inc;
  assign t_read = read_sample_r <= elapsed_inc;

  // phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    step_ph   = phase_r;
    run_laen  = 1'b0;
    run_addr  = 1'b0;
    run_ladi  = 1'b0;
    run_data  = 1'b0;
    run_read  = 1'b0;
    if (req) begin
      phase_nxt = mode_nxt[MODE_LA] ? PH_LAEN : PH_ADDR;
    end else if (tick) begin
      run_laen = (step_ph == PH_LAEN) && t_laen;
      if (run_laen) step_ph = PH_ADDR;
      run_addr = (step_ph == PH_ADDR) && t_addr;
      if (run_addr) step_ph = mode_r[MODE_LA] ? PH_LADI : PH_DATA;
      run_ladi = (step_ph == PH_LADI) && t_ladi;
      if (run_ladi) step_ph = PH_DATA;
      run_data = (step_ph == PH_DATA) && t_data;
      if (run_data) step_ph = is_read_r ? PH_READ : PH_IDLE;
      run_read = (step_ph == PH_READ) && t_read;
      if (run_read) step_ph = PH_IDLE;
      phase_nxt = step_ph;
    end
  end

  // pin, strobe and access datapath
  always_comb begin
    elapsed_nxt  = elapsed_r;
    is_read_nxt  = is_read_r;
    acc_addr_nxt = acc_addr_r;
    acc_data_nxt = acc_data_r;
    rw_nxt       = rw_r;
    enable_nxt   = enable_r;
    latch_nxt    = latch_r;
    addr_pin_nxt = addr_pin_r;
    data_out_nxt = data_out_r;
    drive_nxt    = drive_r;
    captured_nxt = captured_r;
    if (req) begin
      elapsed_nxt  = '0;
      is_read_nxt  = (s1_kind_r == KIND_READ);
      acc_addr_nxt = s1_address_r;
      if (s1_kind_r == KIND_WRITE) acc_data_nxt = s1_write_value_r;
    end else if (tick) begin
      elapsed_nxt = elapsed_inc;
      if (run_laen) latch_nxt = 1'b1;
      if (run_addr) begin
        if (mode_r[MODE_RW]) rw_nxt = is_read_r;
        if (mode_r[MODE_LA]) begin
          data_out_nxt = acc_addr_r[DATA_W-1:0];
          drive_nxt    = 1'b1;
          addr_pin_nxt = {{HIGH_SHIFT{1'b0}}, acc_addr_r[ADDR_W-1:HIGH_SHIFT]};
        end else begin
          addr_pin_nxt = acc_addr_r;
        end
      end
      if (run_ladi) latch_nxt = 1'b0;
      if (run_data) begin
        if (is_read_r) begin
          drive_nxt = 1'b0;
          if (mode_r[MODE_EN]) enable_nxt = 1'b0;
        end else begin
          data_out_nxt = acc_data_r;
          drive_nxt    = 1'b1;
        end
      end
      if (run_read) begin
        captured_nxt = s1_bus_r;
        if (mode_r[MODE_EN]) enable_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_on_r    <= '0;
      address_t_r   <= '0;
      latch_off_r   <= '0;
      read_setup_r  <= '0;
      write_setup_r <= '0;
      read_sample_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LATCH_ON:    latch_on_r    <= cfg_data;
        CFG_ADDRESS:     address_t_r   <= cfg_data;
        CFG_LATCH_OFF:   latch_off_r   <= cfg_data;
        CFG_READ_SETUP:  read_setup_r  <= cfg_data;
        CFG_WRITE_SETUP: write_setup_r <= cfg_data;
        CFG_READ_SAMPLE: read_sample_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r        <= in_kind;
      s1_address_r     <= in_address;
      s1_write_value_r <= in_write_value;
      s1_mode_r        <= in_mode_flags;
      s1_bus_r         <= in_bus_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      elapsed_r  <= '0;
      is_read_r  <= 1'b1;
      mode_r     <= '0;
      acc_addr_r <= '0;
      acc_data_r <= '0;
      rw_r       <= 1'b1;
      enable_r   <= 1'b1;
      latch_r    <= 1'b0;
      addr_pin_r <= '0;
      data_out_r <= '0;
      drive_r    <= 1'b0;
      captured_r <= '0;
    end else if (s1_fire) begin
      phase_r    <= phase_nxt;
      elapsed_r  <= elapsed_nxt;
      is_read_r  <= is_read_nxt;
      mode_r     <= mode_nxt;
      acc_addr_r <= acc_addr_nxt;
      acc_data_r <= acc_data_nxt;
      rw_r       <= rw_nxt;
      enable_r   <= enable_nxt;
      latch_r    <= latch_nxt;
      addr_pin_r <= addr_pin_nxt;
      data_out_r <= data_out_nxt;
      drive_r    <= drive_nxt;
      captured_r <= captured_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_rw_level        <= rw_nxt;
      out_enable_level    <= enable_nxt;
      out_latch_level     <= latch_nxt;
      out_address_pins    <= addr_pin_nxt;
      out_data_pins_out   <= data_out_nxt;
      out_data_pins_drive <= drive_nxt;
      out_read_value      <= captured_nxt;
      out_read_done       <= run_read;
      out_busy_res        <= (phase_nxt != PH_IDLE);
      out_overlap_error   <= req && (phase_r != PH_IDLE);
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/embs_checker.sv =====
// Port checker for the external memory bus sequencer, with its bind
`include "external_memory_bus_sequencer_assert.svh"

module embs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_value,
  input logic       out_read_done,
  input logic       out_busy_res,
  input logic       out_overlap_error,
  input logic       out_data_pins_drive
);

  `EMBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_read_value))
  `EMBS_ASSERT_NOW(a_done_ends_access, out_valid && out_read_done, !out_busy_res)
  `EMBS_ASSERT_NOW(a_overlap_busy, out_valid && out_overlap_error, out_busy_res)
  `EMBS_ASSERT_NOW(a_done_pins_input, out_valid && out_read_done, !out_data_pins_drive)

endmodule

bind external_memory_bus_sequencer embs_checker u_embs_checker (.*);
